// ----- hdl/u8d_pkg.sv -----
package u8d_pkg;

  localparam int unsigned NumClasses = 12;
  localparam int unsigned NumStates  = 9;

  typedef logic [3:0]  u8d_state_t;
  typedef logic [3:0]  u8d_class_t;
  typedef logic [20:0] u8d_cp_t;

  localparam u8d_state_t StAccept = 4'd0;
  localparam u8d_state_t StReject = 4'd1;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrInvalid = 2'd1,
    ErrTrunc   = 2'd2
  } u8d_err_e;

  // Next state, row per automaton state, column per byte class
  localparam u8d_state_t NextState [NumStates * NumClasses] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  function automatic u8d_class_t byte_class(input logic [7:0] b);
    u8d_class_t c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  function automatic u8d_state_t next_state(input u8d_state_t s, input u8d_class_t c);
    logic [6:0] idx;
    idx = 7'(s) * 7'(NumClasses) + 7'(c);
    return NextState[idx];
  endfunction

endpackage

// ----- hdl/u8d_in_if.sv -----
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

// ----- hdl/u8d_out_if.sv -----
interface u8d_out_if;
  logic                valid;
  logic                ready;
  u8d_pkg::u8d_cp_t    code_point;
  logic                code_valid;
  logic [1:0]          error_kind;
  logic                end_of_string;

  modport source (output valid, output code_point, output code_valid, output error_kind,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_point, input code_valid, input error_kind,
                  input end_of_string, output ready);
endinterface

// ----- hdl/utf8_validating_decoder_unit.sv -----
// Channel | Dir | Payload                                           | Transaction
// in_i    | in  | data_byte[7:0], first_byte, last_byte             | one string byte
// out_o   | out | code_point[20:0], code_valid, error_kind, end_of_string | one result
//
// One byte per cycle sustained while out_o does not stall.
// The byte goes to an input register, then class lookup, automaton step and
// accumulator update run combinationally into the result register.
// Reset puts the automaton in accept with a zero accumulator; no result is pending.
// A byte that causes no result is consumed without touching the output.
// A stall on out_o holds the pending result and the input register; in_i stays
// ready while the input register is empty.
module utf8_validating_decoder_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  u8d_in_if.sink           in_i,
  u8d_out_if.source        out_o
);

  logic       stg_vld_q;
  logic [7:0] stg_byte_q;
  logic       stg_first_q;
  logic       stg_last_q;

  u8d_pkg::u8d_state_t dfa_state_q, dfa_state_d;
  u8d_pkg::u8d_cp_t    acc_q, acc_d;

  logic               out_vld_q;
  u8d_pkg::u8d_cp_t   out_cp_q, out_cp_d;
  logic               out_cv_q, out_cv_d;
  u8d_pkg::u8d_err_e  out_err_q, out_err_d;
  logic               out_eos_q;
  logic               res_vld;

  logic advance;
  logic in_take;

  u8d_pkg::u8d_state_t old_state;
  u8d_pkg::u8d_state_t nxt_state;
  u8d_pkg::u8d_class_t cls;
  u8d_pkg::u8d_cp_t    acc_base;

  assign advance  = stg_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !stg_vld_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    old_state = stg_first_q ? u8d_pkg::StAccept : dfa_state_q;
    if (old_state > 4'(u8d_pkg::NumStates - 1)) begin
      old_state = u8d_pkg::StReject;
    end
    acc_base  = stg_first_q ? '0 : acc_q;
    cls       = u8d_pkg::byte_class(stg_byte_q);
    nxt_state = u8d_pkg::next_state(old_state, cls);
    if (old_state != u8d_pkg::StAccept) begin
      acc_d = {acc_base[14:0], stg_byte_q[5:0]};
    end else begin
      acc_d = {13'd0, (8'hFF >> cls) & stg_byte_q};
    end
    dfa_state_d = nxt_state;

    out_cp_d  = '0;
    out_cv_d  = 1'b0;
    out_err_d = u8d_pkg::ErrNone;
    res_vld   = 1'b0;
    if (nxt_state == u8d_pkg::StAccept) begin
      out_cp_d = acc_d;
      out_cv_d = 1'b1;
      res_vld  = 1'b1;
    end else if (nxt_state == u8d_pkg::StReject && old_state != u8d_pkg::StReject) begin
      out_err_d = u8d_pkg::ErrInvalid;
      res_vld   = 1'b1;
    end else if (stg_last_q) begin
      out_err_d = (nxt_state == u8d_pkg::StReject) ? u8d_pkg::ErrInvalid : u8d_pkg::ErrTrunc;
      res_vld   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      dfa_state_q <= u8d_pkg::StAccept;
      acc_q       <= '0;
    end else begin
      if (in_take) begin
        stg_vld_q <= 1'b1;
      end else if (advance) begin
        stg_vld_q <= 1'b0;
      end
      if (advance) begin
        dfa_state_q <= dfa_state_d;
        acc_q       <= acc_d;
        out_vld_q   <= res_vld;
      end else if (out_o.ready) begin
        out_vld_q   <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stg_byte_q  <= in_i.data_byte;
      stg_first_q <= in_i.first_byte;
      stg_last_q  <= in_i.last_byte;
    end
    if (advance && res_vld) begin
      out_cp_q  <= out_cp_d;
      out_cv_q  <= out_cv_d;
      out_err_q <= out_err_d;
      out_eos_q <= stg_last_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.code_point    = out_cp_q;
  assign out_o.code_valid    = out_cv_q;
  assign out_o.error_kind    = out_err_q;
  assign out_o.end_of_string = out_eos_q;

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dfa_state_q <= 4'(u8d_pkg::NumStates - 1))
    else $error("automaton state out of range");

  a_code_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_cv_q |-> out_err_q == u8d_pkg::ErrNone)
    else $error("code point result carries an error");

  a_err_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_cv_q |-> out_err_q != u8d_pkg::ErrNone && out_cp_q == '0)
    else $error("empty result without error");

  a_trunc_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_err_q == u8d_pkg::ErrTrunc |-> out_eos_q)
    else $error("truncation reported before end of string");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q && !advance |=> stg_vld_q && $stable(stg_byte_q))
    else $error("input register lost a byte under stall");

endmodule

// ----- tb/sv/u8d_decode_checker.sv -----
`timescale 1ns / 100ps

module u8d_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8d_in_if           in_i,
  u8d_out_if          out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam u8d_pkg::u8d_state_t SNeed1   = 4'd2;
  localparam u8d_pkg::u8d_state_t SNeed2   = 4'd3;
  localparam u8d_pkg::u8d_state_t SAfterE0 = 4'd4;
  localparam u8d_pkg::u8d_state_t SAfterED = 4'd5;
  localparam u8d_pkg::u8d_state_t SAfterF0 = 4'd6;
  localparam u8d_pkg::u8d_state_t SNeed3   = 4'd7;
  localparam u8d_pkg::u8d_state_t SAfterF4 = 4'd8;

  localparam u8d_pkg::u8d_class_t ClsAscii  = 4'd0;
  localparam u8d_pkg::u8d_class_t ClsCont8x = 4'd1;
  localparam u8d_pkg::u8d_class_t ClsLead2  = 4'd2;
  localparam u8d_pkg::u8d_class_t ClsLead3  = 4'd3;
  localparam u8d_pkg::u8d_class_t ClsLeadED = 4'd4;
  localparam u8d_pkg::u8d_class_t ClsLeadF4 = 4'd5;
  localparam u8d_pkg::u8d_class_t ClsLead4  = 4'd6;
  localparam u8d_pkg::u8d_class_t ClsContAx = 4'd7;
  localparam u8d_pkg::u8d_class_t ClsBad    = 4'd8;
  localparam u8d_pkg::u8d_class_t ClsCont9x = 4'd9;
  localparam u8d_pkg::u8d_class_t ClsLeadE0 = 4'd10;
  localparam u8d_pkg::u8d_class_t ClsLeadF0 = 4'd11;

  typedef struct packed {
    u8d_pkg::u8d_cp_t  code_point;
    logic              code_valid;
    u8d_pkg::u8d_err_e error_kind;
    logic              end_of_string;
  } decode_result_t;

  u8d_pkg::u8d_state_t dec_state;
  u8d_pkg::u8d_cp_t    dec_acc;
  decode_result_t      decoded_q [$];

  function automatic u8d_pkg::u8d_class_t classify(input logic [7:0] b);
    if (!b[7]) return ClsAscii;
    // continuation bytes split on bits 5 and 4: 80-8F, 90-9F, A0-BF
    if (b < 8'hC0) return b[5] ? ClsContAx : (b[4] ? ClsCont9x : ClsCont8x);
    if (b < 8'hC2) return ClsBad;
    if (b < 8'hE0) return ClsLead2;
    if (b == 8'hE0) return ClsLeadE0;
    if (b == 8'hED) return ClsLeadED;
    if (b < 8'hF0) return ClsLead3;
    if (b == 8'hF0) return ClsLeadF0;
    if (b < 8'hF4) return ClsLead4;
    if (b == 8'hF4) return ClsLeadF4;
    return ClsBad;
  endfunction

  function automatic u8d_pkg::u8d_state_t step_state(input u8d_pkg::u8d_state_t s,
                                                     input u8d_pkg::u8d_class_t c);
    logic is_cont;
    is_cont = (c == ClsCont8x) || (c == ClsCont9x) || (c == ClsContAx);
    case (s)
      u8d_pkg::StAccept: begin
        case (c)
          ClsAscii:  return u8d_pkg::StAccept;
          ClsLead2:  return SNeed1;
          ClsLead3:  return SNeed2;
          ClsLeadE0: return SAfterE0;
          ClsLeadED: return SAfterED;
          ClsLead4:  return SNeed3;
          ClsLeadF0: return SAfterF0;
          ClsLeadF4: return SAfterF4;
          default:   return u8d_pkg::StReject;
        endcase
      end
      SNeed1:   if (is_cont) return u8d_pkg::StAccept;
      SNeed2:   if (is_cont) return SNeed1;
      // no overlong three-byte forms, no surrogates
      SAfterE0: if (c == ClsContAx) return SNeed1;
      SAfterED: if (is_cont && c != ClsContAx) return SNeed1;
      SNeed3:   if (is_cont) return SNeed2;
      // no overlong four-byte forms, nothing above 10FFFF
      SAfterF0: if (is_cont && c != ClsCont8x) return SNeed2;
      SAfterF4: if (c == ClsCont8x) return SNeed2;
      default: ;
    endcase
    return u8d_pkg::StReject;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic first, input logic last,
                                     output decode_result_t res);
    u8d_pkg::u8d_class_t cls;
    u8d_pkg::u8d_state_t prev;
    cls = classify(b);
    if (first) begin
      dec_state = u8d_pkg::StAccept;
      dec_acc   = '0;
    end
    prev = dec_state;
    if (prev != u8d_pkg::StAccept) dec_acc = {dec_acc[14:0], b[5:0]};
    else dec_acc = u8d_pkg::u8d_cp_t'((8'hFF >> cls) & b);
    dec_state = step_state(prev, cls);
    res = '{code_point: '0, code_valid: 1'b0, error_kind: u8d_pkg::ErrNone,
            end_of_string: last};
    if (dec_state == u8d_pkg::StAccept) begin
      res.code_point = dec_acc;
      res.code_valid = 1'b1;
      return 1'b1;
    end
    if (dec_state == u8d_pkg::StReject && prev != u8d_pkg::StReject) begin
      res.error_kind = u8d_pkg::ErrInvalid;
      return 1'b1;
    end
    if (last) begin
      res.error_kind = (dec_state == u8d_pkg::StReject) ? u8d_pkg::ErrInvalid
                                                        : u8d_pkg::ErrTrunc;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    $display("%0t ns: decoder mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t want, res;
    if (!rst_ni) begin
      dec_state        = u8d_pkg::StAccept;
      dec_acc          = '0;
      decoded_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // compare first: a byte taken at this edge cannot have produced the result seen here
      if (out_i.valid && out_i.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (cp %h valid %b err %0d eos %b)",
                                    out_i.code_point, out_i.code_valid, out_i.error_kind,
                                    out_i.end_of_string));
        end else begin
          want = decoded_q.pop_front();
          if (out_i.code_point !== want.code_point)
            report_mismatch($sformatf("code_point %h, want %h",
                                      out_i.code_point, want.code_point));
          if (out_i.code_valid !== want.code_valid)
            report_mismatch($sformatf("code_valid %b, want %b",
                                      out_i.code_valid, want.code_valid));
          if (out_i.error_kind !== want.error_kind)
            report_mismatch($sformatf("error_kind %0d, want %s",
                                      out_i.error_kind, want.error_kind.name()));
          if (out_i.end_of_string !== want.end_of_string)
            report_mismatch($sformatf("end_of_string %b, want %b",
                                      out_i.end_of_string, want.end_of_string));
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (decode_byte(in_i.data_byte, in_i.first_byte, in_i.last_byte, res))
          decoded_q = {decoded_q, res};
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned StallPct      = 11;
  localparam int unsigned RandomBytes   = 1400;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  typedef logic [7:0] byte_q_t [$];

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        calm  = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent_bytes;
  int unsigned idle_cycles;

  u8d_in_if  in_if ();
  u8d_out_if out_if ();

  utf8_validating_decoder_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  u8d_decode_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_i             (in_if),
    .out_i            (out_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(negedge clk) out_if.ready <= calm || ($urandom_range(99) >= StallPct);

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
    while (!calm && $urandom_range(99) < StallPct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.first_byte <= first;
    in_if.last_byte  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic push_string(input byte_q_t s, input bit mark_first, input bit mark_last,
                             input bit scatter);
    foreach (s[i])
      push_byte(s[i],
                (i == 0 && mark_first) || (scatter && $urandom_range(49) == 0),
                (i == s.size() - 1 && mark_last) || (scatter && $urandom_range(49) == 0));
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [20:0] pick_scalar();
    logic [20:0] cp;
    case ($urandom_range(3))
      0: cp = 21'($urandom_range(32'h7F));
      1: cp = 21'($urandom_range(32'h7FF, 32'h80));
      2: begin
        do cp = 21'($urandom_range(32'hFFFF, 32'h800));
        while (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
    endcase
    return cp;
  endfunction

  function automatic byte_q_t utf8_encode(input logic [20:0] cp);
    byte_q_t q;
    if (cp < 21'h80) q = '{cp[7:0]};
    else if (cp < 21'h800) q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    else if (cp < 21'h10000)
      q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    else
      q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    return q;
  endfunction

  initial begin
    byte_q_t     str, enc;
    int unsigned n_chars, n_strings;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    sent_bytes       = 0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_string('{8'h00}, 1, 1, 0);
    push_string('{8'h7F, 8'hDF, 8'hBF}, 1, 1, 0);
    push_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1, 1, 0);
    push_string('{8'hF0, 8'h90, 8'h80, 8'h80}, 1, 1, 0);
    push_string('{8'hE0, 8'hA0, 8'h80}, 1, 1, 0);
    push_string('{8'hED, 8'h9F, 8'hBF}, 1, 1, 0);
    // surrogate lead-in rejected on its second byte
    push_string('{8'hED, 8'hA0}, 1, 1, 0);
    // bad lead, then the last byte lands in the held reject
    push_string('{8'hC0, 8'hFF}, 1, 1, 0);
    // end of string in the middle of a sequence
    push_string('{8'hE1, 8'h80}, 1, 1, 0);
    // stray continuation, then a string without a first marker stays rejected
    push_string('{8'h80}, 1, 0, 0);
    push_string('{8'h41}, 0, 1, 0);

    sent_bytes = 0;
    n_strings  = 0;
    while (sent_bytes < RandomBytes) begin
      if (n_strings == 40) hold_until_drained();
      calm = (n_strings >= 80 && n_strings < 120);
      str = {};
      n_chars = $urandom_range(8, 1);
      repeat (n_chars) begin
        enc = utf8_encode(pick_scalar());
        case ($urandom_range(29))
          0: enc = '{8'($urandom_range(255))};
          1: if (enc.size() > 1) enc = enc[0:$urandom_range(enc.size() - 2)];
          2: enc[$urandom_range(enc.size() - 1)] = 8'($urandom_range(255));
          default: ;
        endcase
        str = {str, enc};
      end
      push_string(str, $urandom_range(9) != 0, $urandom_range(9) != 0, $urandom_range(4) == 0);
      n_strings++;
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/u8d_pkg.sv
hdl/u8d_in_if.sv
hdl/u8d_out_if.sv
hdl/utf8_validating_decoder_unit.sv
tb/sv/u8d_decode_checker.sv
tb/sv/tb.sv
